/* rtl/core/uleb_pkg.sv */
// Shared types, codes and helpers for the ULEB128 stream decoder.
package uleb_pkg;

    // decode_mode codes
    localparam logic [1:0] MODE_32   = 2'd0;
    localparam logic [1:0] MODE_64   = 2'd1;
    localparam logic [1:0] MODE_SKIP = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LONG  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // byte limits per mode
    localparam logic [3:0] LIMIT_32   = 4'd5;
    localparam logic [3:0] LIMIT_64   = 4'd10;
    localparam logic [3:0] LIMIT_SKIP = 4'd9;

    // largest payload allowed in the limit byte
    localparam logic [6:0] MAXBITS_32 = 7'd15;
    localparam logic [6:0] MAXBITS_64 = 7'd1;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 4;

    // outcome of one byte
    typedef struct packed {
        logic                 emit;
        logic [VALUE_W-1:0]   value;
        logic [1:0]           status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   acc_next;
        logic [COUNT_W-1:0]   seen_next;
    } t_step;

    // bit position of byte number n (from 1): 7*(n-1)
    function automatic logic [5:0] shift_of(input logic [COUNT_W-1:0] n);
        logic [5:0] sh;
        sh = 6'd0;
        unique case (n)
            4'd2:    sh = 6'd7;
            4'd3:    sh = 6'd14;
            4'd4:    sh = 6'd21;
            4'd5:    sh = 6'd28;
            4'd6:    sh = 6'd35;
            4'd7:    sh = 6'd42;
            4'd8:    sh = 6'd49;
            4'd9:    sh = 6'd56;
            4'd10:   sh = 6'd63;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

endpackage

/* rtl/core/uleb_step.sv */
// Per-byte decode logic: judges one byte against the running number state.
module uleb_step (
    input  logic [7:0]                   i_byte,
    input  logic                         i_last,
    input  logic [1:0]                   i_mode,
    input  logic [uleb_pkg::VALUE_W-1:0] i_acc,
    input  logic [uleb_pkg::COUNT_W-1:0] i_seen,
    output uleb_pkg::t_step              o_step
);

    logic                         cont;
    logic [6:0]                   bits;
    logic [uleb_pkg::COUNT_W-1:0] n;
    logic                         skip;
    logic [uleb_pkg::COUNT_W-1:0] limit;
    logic [6:0]                   maxbits;
    logic [uleb_pkg::VALUE_W-1:0] placed;
    logic [uleb_pkg::VALUE_W-1:0] merged;

    assign cont   = i_byte[7];
    assign bits   = i_byte[6:0];
    assign n      = i_seen + 4'd1;
    assign placed = {57'd0, bits} << uleb_pkg::shift_of(n);
    assign merged = i_acc | placed;

    // mode decode
    always_comb begin
        skip    = 1'b0;
        limit   = uleb_pkg::LIMIT_64;
        maxbits = uleb_pkg::MAXBITS_64;
        unique case (i_mode)
            uleb_pkg::MODE_32: begin
                limit   = uleb_pkg::LIMIT_32;
                maxbits = uleb_pkg::MAXBITS_32;
            end
            uleb_pkg::MODE_64: begin
                limit   = uleb_pkg::LIMIT_64;
            end
            default: begin
                // reserved code behaves as skip
                skip    = 1'b1;
                limit   = uleb_pkg::LIMIT_SKIP;
            end
        endcase
    end

    // outcome selection
    always_comb begin
        o_step.emit      = 1'b1;
        o_step.value     = '0;
        o_step.status    = uleb_pkg::ST_OK;
        o_step.count     = n;
        o_step.acc_next  = '0;
        o_step.seen_next = '0;
        if (n > limit) begin
            // past the current limit (mode changed mid-number)
            o_step.status = uleb_pkg::ST_LONG;
        end else if (n == limit) begin
            if (skip) begin
                if (cont) begin
                    o_step.status = i_last ? uleb_pkg::ST_TRUNC : uleb_pkg::ST_LONG;
                end
            end else if (bits > maxbits || cont) begin
                o_step.status = uleb_pkg::ST_LONG;
            end else begin
                o_step.value = merged;
            end
        end else if (!cont) begin
            o_step.value = skip ? '0 : merged;
        end else if (i_last) begin
            o_step.status = uleb_pkg::ST_TRUNC;
        end else begin
            // continuation byte: carry the number state forward, no result
            o_step.emit      = 1'b0;
            o_step.acc_next  = skip ? i_acc : merged;
            o_step.seen_next = n;
        end
    end

endmodule

/* rtl/core/uleb128_stream_decoder_unit.sv */
// Top level of the ULEB128 stream decoder: input register, number state, result register.
//
// Usage:
//   Slave stream carries one encoded byte per transfer in i_s_tdata, with
//   i_s_tlast set on the final byte available in the buffer. The master
//   stream carries one result per decoded number (or error) in o_m_tdata.
//   Continuation bytes that neither finish nor fail a number give no result.
//   decode_mode is written through i_cfg_we / i_cfg_wdata while idle.
// Timing:
//   A byte is registered at its transfer; once the result register can take
//   a result, the per-byte logic updates the number state and loads the
//   result register, which drives o_m_tvalid for the ending byte. One byte per
//   cycle is sustained while results are taken, since the step between the
//   input and result registers is combinational.
// Reset:
//   Both registers empty, number state cleared, decode_mode = 64-bit.
// Stall:
//   A waiting result holds; the input register still takes one byte, then
//   o_s_tready drops until the result is taken.
module uleb128_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,   // decode_mode
    // byte input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] byte_in
    input  logic        i_s_tlast,     // last_in_buffer
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata      // [63:0] value, [65:64] status,
                                       // [69:66] byte_count, [71:70] zero
);

    logic [1:0]                   r_mode;
    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_last;
    logic [uleb_pkg::VALUE_W-1:0] r_acc;
    logic [uleb_pkg::COUNT_W-1:0] r_seen;
    logic                         r_out_valid;
    logic [uleb_pkg::VALUE_W-1:0] r_out_value;
    logic [1:0]                   r_out_status;
    logic [uleb_pkg::COUNT_W-1:0] r_out_count;

    logic                         advance;
    logic                         in_xfer;
    uleb_pkg::t_step              step;

    // pipeline control
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    uleb_step u_step (
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .i_mode (r_mode),
        .i_acc  (r_acc),
        .i_seen (r_seen),
        .o_step (step)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= uleb_pkg::MODE_64;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // number state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_seen <= '0;
        end else if (advance) begin
            r_acc  <= step.acc_next;
            r_seen <= step.seen_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step.emit) begin
            r_out_value  <= step.value;
            r_out_status <= step.status;
            r_out_count  <= step.count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_count, r_out_status, r_out_value};

endmodule

/* rtl/core/uleb_checker.sv */
// Port-level checker for the ULEB128 stream decoder, bound to the top level.
module uleb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] o_m_tdata
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // byte count of every result is one to ten
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[69:66] != 4'd0 && o_m_tdata[69:66] <= 4'd10))
        else $error("byte count out of range");

    // an error result carries value zero and a known status
    a_errval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65:64] != uleb_pkg::ST_OK
        |-> (o_m_tdata[63:0] == 64'd0 && o_m_tdata[65:64] != 2'd3))
        else $error("bad error result");

    // result register empties on reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind uleb128_stream_decoder_unit uleb_checker u_uleb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
